// ===== rtl/assert_macros.svh =====
// assert_macros.svh: assertion macros for the Sobel block checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent check with async reset disable
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

// ===== rtl/sgm_pkg.sv =====
// sgm_pkg: constants and types for the Sobel gradient magnitude block.
// No dependencies.
package sgm_pkg;
	localparam int MaxWidth  = 2048;
	localparam int MaxHeight = 4096;
	localparam int ColW = $clog2(MaxWidth);
	localparam int RowW = $clog2(MaxHeight);
	localparam int SqW  = 22;
	localparam int RootW = SqW / 2;
	localparam int RootSteps = RootW;

	localparam logic [1:0] RegWidth  = 2'd0;
	localparam logic [1:0] RegHeight = 2'd1;

	// one pending result traveling down the root chain
	// root carries the running partial root, as wide as the remainder
	typedef struct packed {
		logic             vld;
		logic [SqW-1:0]   rem;
		logic [SqW-1:0]   root;
		logic [7:0]       ax;
		logic [7:0]       ay;
		logic             eof;
	} sgm_cell_t;
endpackage

// ===== rtl/sgm_ram.sv =====
// sgm_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module sgm_ram #(
	parameter int Width = 8,
	parameter int Depth = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/sgm_root_cell.sv =====
// sgm_root_cell: one restoring square-root step, one bit of the root per cell.
// Depends on sgm_pkg.
module sgm_root_cell
	import sgm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic [4:0]  step,
	input  sgm_cell_t   din,
	output sgm_cell_t   dout
);
	logic [SqW-1:0] trial;
	logic [SqW-1:0] bitv;
	sgm_cell_t      nxt;

	// trial subtract of root+bit, as in the digit-by-digit method
	always_comb begin
		bitv = '0;
		bitv[SqW - 2 - 2 * step] = 1'b1;
		trial = din.root + bitv;
		nxt = din;
		if (din.rem >= trial) begin
			nxt.rem  = din.rem - trial;
			nxt.root = (din.root >> 1) + bitv;
		end else begin
			nxt.root = din.root >> 1;
		end
	end

	// hold while the pipe is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout <= '0;
		end else if (en) begin
			dout <= nxt;
		end
	end
endmodule

// ===== rtl/sobel_gradient_magnitude.sv =====
// sobel_gradient_magnitude: streaming 3x3 Sobel, |gx|, |gy| and floor sqrt.
// Depends on sgm_pkg, sgm_ram, sgm_root_cell.
// Pipeline: RAM read, window, gradient, square, 11 root cells, output
//   register, in that order. Throughput: one pixel
//   per cycle; the whole pipeline stalls while a result waits unaccepted.
// Reset: arst_n clears positions, window, valids; width 640, height 480.
//   Line stores need no clearing: unwritten entries never reach a result.
module sobel_gradient_magnitude
	import sgm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        pixel_valid,
	output logic        pixel_ready,
	input  logic [7:0]  pixel_value,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  magnitude,
	output logic [7:0]  grad_x_abs,
	output logic [7:0]  grad_y_abs,
	output logic        end_of_frame
);
	logic [11:0] width_q;
	logic [12:0] height_q;
	logic [ColW:0] wc;
	logic [RowW:0] hc;
	logic [ColW-1:0] col_q;
	logic [RowW-1:0] row_q;
	logic adv, acc, cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel & penable & pwrite;
	assign adv = !result_valid | result_ready;
	assign pixel_ready = adv;
	assign acc = pixel_valid & adv;

	// register read
	always_comb begin
		case (paddr[2])
			RegWidth[0]:  prdata = {20'd0, width_q};
			default:      prdata = {19'd0, height_q};
		endcase
	end

	// clamped dimensions
	always_comb begin
		if (width_q < 12'd3) wc = (ColW+1)'(3);
		else if (width_q > 12'(MaxWidth)) wc = (ColW+1)'(MaxWidth);
		else wc = (ColW+1)'(width_q);
		if (height_q < 13'd3) hc = (RowW+1)'(3);
		else if (height_q > 13'(MaxHeight)) hc = (RowW+1)'(MaxHeight);
		else hc = (RowW+1)'(height_q);
	end

	// config and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 12'd640;
			height_q <= 13'd480;
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_we && (paddr[2] == RegWidth[0] || paddr[2] == RegHeight[0])) begin
			if (paddr[2] == RegWidth[0]) width_q <= pwdata[11:0];
			else height_q <= pwdata[12:0];
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if ((ColW+1)'(col_q) + 1'b1 >= wc) begin
				col_q <= '0;
				if ((RowW+1)'(row_q) + 1'b1 >= hc) row_q <= '0;
				else row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stage 1: read line stores, hold pixel
	logic [7:0] top_rd, mid_rd, pix_s1;
	logic [ColW-1:0] col_s1;
	logic vld_s1, out_s1, eof_s1;
	sgm_ram #(.Width(8), .Depth(MaxWidth)) u_older (
		.clk, .we(vld_s1 & adv), .waddr(col_s1), .wdata(mid_rd),
		.re(acc), .raddr(col_q), .rdata(top_rd)
	);
	sgm_ram #(.Width(8), .Depth(MaxWidth)) u_newer (
		.clk, .we(vld_s1 & adv), .waddr(col_s1), .wdata(pix_s1),
		.re(acc), .raddr(col_q), .rdata(mid_rd)
	);

	// read-after-write forwarding when a row is narrower than the pipe
	logic fwd;
	logic [7:0] top_f, mid_f, mid_last_q, pix_last_q;
	logic [ColW-1:0] col_last_q;
	logic last_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			last_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= acc;
			last_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_s1 <= pixel_value;
			col_s1 <= col_q;
			out_s1 <= row_q >= RowW'(2) && col_q >= ColW'(2);
			eof_s1 <= (RowW+1)'(row_q) == hc - 1'b1 && (ColW+1)'(col_q) == wc - 1'b1;
			col_last_q <= col_s1;
			mid_last_q <= mid_f;
			pix_last_q <= pix_s1;
		end
	end

	// the previous beat wrote the same address in the same cycle as this read
	assign fwd = last_vld_q && col_last_q == col_s1;
	assign top_f = fwd ? mid_last_q : top_rd;
	assign mid_f = fwd ? pix_last_q : mid_rd;

	// stage 2: window shift
	logic [23:0] win_q [3];
	logic vld_s2, out_s2, eof_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q[0] <= '0;
			win_q[1] <= '0;
			win_q[2] <= '0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1 & out_s1;
			if (vld_s1) begin
				win_q[0] <= win_q[1];
				win_q[1] <= win_q[2];
				win_q[2] <= {pix_s1, mid_f, top_f};
			end
		end
	end
	always_ff @(posedge clk) begin
		if (adv) eof_s2 <= eof_s1;
	end
	assign out_s2 = vld_s2;

	// stage 3: gradients and absolute values
	logic signed [11:0] gx, gy;
	logic [10:0] ax, ay;
	logic [10:0] ax_s3, ay_s3;
	logic vld_s3, eof_s3;
	always_comb begin
		gx = 12'(win_q[2][7:0]) + 12'({win_q[2][15:8], 1'b0}) + 12'(win_q[2][23:16])
		   - 12'(win_q[0][7:0]) - 12'({win_q[0][15:8], 1'b0}) - 12'(win_q[0][23:16]);
		gy = 12'(win_q[0][23:16]) + 12'({win_q[1][23:16], 1'b0}) + 12'(win_q[2][23:16])
		   - 12'(win_q[0][7:0]) - 12'({win_q[1][7:0], 1'b0}) - 12'(win_q[2][7:0]);
		ax = gx[11] ? 11'(-gx) : 11'(gx);
		ay = gy[11] ? 11'(-gy) : 11'(gy);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= out_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s3 <= ax;
			ay_s3 <= ay;
			eof_s3 <= eof_s2;
		end
	end

	// stage 4: squares, into the root chain
	sgm_cell_t chain [RootSteps+1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain[0] <= '0;
		end else if (adv) begin
			chain[0].vld <= vld_s3;
			chain[0].rem <= SqW'(ax_s3 * ax_s3) + SqW'(ay_s3 * ay_s3);
			chain[0].root <= '0;
			chain[0].ax <= ax_s3 > 11'd255 ? 8'hff : ax_s3[7:0];
			chain[0].ay <= ay_s3 > 11'd255 ? 8'hff : ay_s3[7:0];
			chain[0].eof <= eof_s3;
		end
	end

	// root cells, all advancing together with the pipe
	for (genvar i = 0; i < RootSteps; i++) begin : g_root
		sgm_root_cell u_cell (
			.clk, .arst_n, .en(adv), .step(5'(i)), .din(chain[i]), .dout(chain[i+1])
		);
	end

	// output register
	logic [SqW-1:0] rt;
	assign rt = chain[RootSteps].root;
	logic [7:0] mag_q;
	logic [7:0] gxa_q, gya_q;
	logic eof_q, rv_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_q <= 1'b0;
		else if (adv) rv_q <= chain[RootSteps].vld;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_q <= rt > SqW'(255) ? 8'hff : rt[7:0];
			gxa_q <= chain[RootSteps].ax;
			gya_q <= chain[RootSteps].ay;
			eof_q <= chain[RootSteps].eof;
		end
	end
	assign result_valid = rv_q;
	assign magnitude = mag_q;
	assign grad_x_abs = gxa_q;
	assign grad_y_abs = gya_q;
	assign end_of_frame = eof_q;
endmodule

// ===== rtl/sgm_checker.sv =====
// sgm_checker: port-level checks for sobel_gradient_magnitude, with bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module sgm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       pixel_ready,
	input logic       result_valid,
	input logic       result_ready,
	input logic [7:0] magnitude,
	input logic [7:0] grad_x_abs,
	input logic [7:0] grad_y_abs,
	input logic       pready
);
	`CHK_ASSERT(a_hold, clk, arst_n, result_valid && !result_ready |=> result_valid && $stable(magnitude), "result dropped while stalled")
	`CHK_ASSERT(a_rdy, clk, arst_n, !result_valid |-> pixel_ready, "input blocked with empty output")
	`CHK_ASSERT(a_mag, clk, arst_n, result_valid && grad_x_abs < 8'd255 && grad_y_abs < 8'd255 |-> magnitude >= grad_x_abs && magnitude >= grad_y_abs, "magnitude below a component")
	`CHK_ASSERT(a_prdy, clk, arst_n, pready, "pready low")
endmodule

bind sobel_gradient_magnitude sgm_checker u_sgm_checker (
	.clk, .arst_n, .pixel_ready, .result_valid, .result_ready,
	.magnitude, .grad_x_abs, .grad_y_abs, .pready
);

// ===== bench/tb_sobel_gradient_magnitude.sv =====
// tb_sobel_gradient_magnitude: self-checking bench for the streaming Sobel block.
// Depends on sgm_pkg and sobel_gradient_magnitude. A scoreboard class predicts
// |gx|, |gy| and magnitude per full-window pixel beat and checks each result beat in order.
module tb_sobel_gradient_magnitude;
	timeunit 1ns;
	timeprecision 1ps;
	import sgm_pkg::*;

	typedef struct packed {
		logic [7:0] mag;
		logic [7:0] gx;
		logic [7:0] gy;
		logic       eof;
	} grad_t;

	// gradient predictor plus queue of pending gradients
	class sobel_scoreboard;
		logic [7:0]  older_row [MaxWidth];
		logic [7:0]  newer_row [MaxWidth];
		logic [23:0] win [3];
		int unsigned width_reg, height_reg, col, row;
		grad_t       pending [$];
		int          errors;

		function new();
			width_reg = 640;
			height_reg = 480;
			col = 0;
			row = 0;
			errors = 0;
			foreach (win[i]) win[i] = '0;
			foreach (older_row[i]) begin
				older_row[i] = '0;
				newer_row[i] = '0;
			end
		endfunction

		function int unsigned clamp(int unsigned v, int unsigned hi);
			if (v < 3) return 3;
			if (v > hi) return hi;
			return v;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] val);
			if (idx == RegWidth) width_reg = 32'(val[11:0]);
			else if (idx == RegHeight) height_reg = 32'(val[12:0]);
			else return;
			col = 0;
			row = 0;
		endfunction

		function int unsigned isqrt(int unsigned v);
			int unsigned r;
			r = 0;
			while ((r + 1) * (r + 1) <= v) r++;
			return r;
		endfunction

		function void note_pixel(logic [7:0] p);
			int unsigned w, h, ax, ay, c, mag;
			int gxs, gys;
			grad_t g;
			w = clamp(width_reg, MaxWidth);
			h = clamp(height_reg, MaxHeight);
			c = col % MaxWidth;
			win[0] = win[1];
			win[1] = win[2];
			win[2] = {p, newer_row[c], older_row[c]};
			older_row[c] = newer_row[c];
			newer_row[c] = p;
			if (row >= 2 && col >= 2) begin
				gxs = int'(win[2][7:0]) + 2 * int'(win[2][15:8]) + int'(win[2][23:16])
					- int'(win[0][7:0]) - 2 * int'(win[0][15:8]) - int'(win[0][23:16]);
				gys = int'(win[0][23:16]) + 2 * int'(win[1][23:16]) + int'(win[2][23:16])
					- int'(win[0][7:0]) - 2 * int'(win[1][7:0]) - int'(win[2][7:0]);
				ax = gxs < 0 ? -gxs : gxs;
				ay = gys < 0 ? -gys : gys;
				mag = isqrt(ax * ax + ay * ay);
				g.mag = mag > 255 ? 8'hff : 8'(mag);
				g.gx = ax > 255 ? 8'hff : 8'(ax);
				g.gy = ay > 255 ? 8'hff : 8'(ay);
				g.eof = (row == h - 1 && col == w - 1);
				pending.push_back(g);
			end
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) row = 0;
			end
		endfunction

		function void check_result(grad_t act);
			grad_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $realtime, act);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (act.mag !== e.mag)
				$display("%0t: magnitude expected %0d actual %0d", $realtime, e.mag, act.mag);
			if (act.gx !== e.gx)
				$display("%0t: grad_x_abs expected %0d actual %0d", $realtime, e.gx, act.gx);
			if (act.gy !== e.gy)
				$display("%0t: grad_y_abs expected %0d actual %0d", $realtime, e.gy, act.gy);
			if (act.eof !== e.eof)
				$display("%0t: end_of_frame expected %0d actual %0d", $realtime, e.eof, act.eof);
			if (act !== e) errors++;
		endfunction
	endclass

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        pixel_valid, pixel_ready, result_valid, result_ready;
	logic [7:0]  pixel_value, magnitude, grad_x_abs, grad_y_abs;
	logic        end_of_frame;
	logic        long_hold, input_done;
	int          pixel_count;

	sobel_scoreboard sb;

	sobel_gradient_magnitude u_top (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// hard stop
	initial begin
		#40ms;
		$display("sobel_gradient_magnitude verification failed");
		$finish;
	end

	// register write: setup then access
	task automatic reg_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx[0], 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic send_pixel(logic [7:0] p, bit gaps);
		int n;
		n = gaps ? $urandom_range(0, 17) : 0;
		if ($urandom_range(0, 3) == 0) n = 0;
		if (n > 0) begin
			@(negedge clk);
			pixel_valid <= 0;
			repeat (n - 1) @(negedge clk);
		end else @(negedge clk);
		pixel_valid <= 1;
		pixel_value <= p;
		@(posedge clk);
		while (!pixel_ready) @(posedge clk);
		sb.note_pixel(p);
		pixel_count++;
	endtask

	task automatic drain();
		@(negedge clk);
		pixel_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// one frame of random or patterned content, by mode
	task automatic send_frame(int w, int h, int mode);
		for (int i = 0; i < w * h; i++)
			case (mode)
				0: send_pixel($urandom_range(0, 255), 1);
				1: send_pixel(((i % w) < w / 2) ? 8'h00 : 8'hff, 1);
				2: send_pixel(((i / w) % 2) ? 8'hff : 8'h00, 0);
				default: send_pixel($urandom_range(0, 1) ? 8'hff : 8'h00, 1);
			endcase
	endtask

	// receiver: random stalls, plus one long hold-off
	initial begin
		result_ready = 0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				result_ready <= 0;
				repeat (300) @(negedge clk);
				long_hold = 0;
			end
			if ($urandom_range(0, 3) == 0) begin
				result_ready <= 0;
				repeat ($urandom_range(1, 17)) @(negedge clk);
			end
			result_ready <= 1;
		end
	end

	always @(posedge clk)
		if (arst_n && result_valid && result_ready)
			sb.check_result({magnitude, grad_x_abs, grad_y_abs, end_of_frame});

	initial begin
		sb = new();
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		pixel_valid = 0; pixel_value = '0;
		long_hold = 0; input_done = 0; pixel_count = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: smallest frame, extreme steps and out-of-range sizes
		reg_write(RegWidth, 3);
		reg_write(RegHeight, 3);
		send_frame(3, 3, 1);
		send_frame(3, 3, 2);
		drain();
		reg_write(RegWidth, 0);
		reg_write(RegHeight, 1);
		send_frame(3, 3, 3);
		drain();

		// restart mid-frame
		reg_write(RegWidth, 5);
		reg_write(RegHeight, 4);
		for (int i = 0; i < 8; i++) send_pixel($urandom_range(0, 255), 1);
		drain();
		reg_write(RegWidth, 5);

		// long receiver hold-off while input keeps being offered
		reg_write(RegWidth, 8);
		reg_write(RegHeight, 8);
		long_hold = 1;
		send_frame(8, 8, 0);
		drain();

		// random frames
		while (pixel_count < 1000) begin
			int w, h;
			w = $urandom_range(3, 12);
			h = $urandom_range(3, 8);
			if ($urandom_range(0, 4) == 0) drain();
			reg_write(RegWidth, w);
			reg_write(RegHeight, h);
			send_frame(w, h, $urandom_range(0, 3));
			if ($urandom_range(0, 6) == 0) send_frame(w, h, 0);
			drain();
		end

		// tall extreme: height clamps, few columns
		reg_write(RegWidth, 3);
		reg_write(RegHeight, 8191);
		for (int i = 0; i < 3 * 20; i++) send_pixel($urandom_range(0, 255), 0);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("sobel_gradient_magnitude verification clean");
		else
			$display("sobel_gradient_magnitude verification failed");
		$finish;
	end
endmodule
